### rtl/core/cheat_code_engine_macros.svh
// assertion helpers shared by the cheat engine rtl
// all of them sample on clk and are quiet while arst_n is low
`ifndef CHEAT_CODE_ENGINE_MACROS_SVH
`define CHEAT_CODE_ENGINE_MACROS_SVH

// condition holds on every clock
`define CCE_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define CCE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define CCE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/cce_pkg.sv
// ----------------------------------------------------------------------------
// cce_pkg
// types, codes and control structs shared by the cheat code engine
// ----------------------------------------------------------------------------
package cce_pkg;

	localparam int MAX_CODES_DEF = 64;

	// config register indexes
	localparam logic REG_CHEAT_ENABLE = 1'b0;
	localparam logic REG_CODE_COUNT   = 1'b1;
	localparam int   CFG_DATA_W       = 7;

	// input word functions
	localparam logic [1:0] FUNC_LOAD  = 2'd0;
	localparam logic [1:0] FUNC_START = 2'd1;
	localparam logic [1:0] FUNC_RDATA = 2'd2;
	localparam logic [1:0] FUNC_WACK  = 2'd3;

	// result kinds and bus sizes
	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_DONE  = 2'd2;
	localparam logic [1:0] SIZE_BYTE  = 2'd0;
	localparam logic [1:0] SIZE_HALF  = 2'd1;
	localparam logic [1:0] SIZE_WORD  = 2'd2;

	// code opcodes
	localparam logic [3:0] OP_OR16   = 4'd2;
	localparam logic [3:0] OP_WR8    = 4'd3;
	localparam logic [3:0] OP_SLIDE  = 4'd4;
	localparam logic [3:0] OP_SUPER  = 4'd5;
	localparam logic [3:0] OP_AND16  = 4'd6;
	localparam logic [3:0] OP_IFEQ   = 4'd7;
	localparam logic [3:0] OP_WR16   = 4'd8;
	localparam logic [3:0] OP_IFNE   = 4'd10;
	localparam logic [3:0] OP_IFGT   = 4'd11;
	localparam logic [3:0] OP_IFLT   = 4'd12;
	localparam logic [3:0] OP_PAD    = 4'd13;
	localparam logic [3:0] OP_ADD    = 4'd14;
	localparam logic [3:0] OP_IFAND  = 4'd15;

	// pad condition selectors
	localparam logic [3:0] PAD_ONLY = 4'd0;
	localparam logic [3:0] PAD_ALL  = 4'd1;
	localparam logic [3:0] PAD_NONE = 4'd2;

	localparam logic [2:0] SUPER_LAST_OFF = 3'd5;

	typedef struct packed {
		logic [1:0]  func;
		logic [5:0]  entry_index;
		logic [31:0] code_word;
		logic [15:0] code_value;
		logic [9:0]  pad;
		logic [31:0] read_data;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] bus_address;
		logic [1:0]  bus_size;
		logic [31:0] write_data;
	} out_item_t;

	typedef enum logic [2:0] {
		PH_IDLE, PH_RD16, PH_RD32, PH_WACK, PH_SLIDE, PH_SUPER
	} phase_t;

	typedef enum logic [3:0] {
		S_WAIT, S_DISPATCH, S_ADV, S_DECODE, S_SLIDE_SET, S_SLIDE_CHK,
		S_SUPER_NEXT, S_SUPER_EMIT
	} state_t;

	typedef enum logic [1:0] {PTR_HOLD, PTR_CLR, PTR_INC1, PTR_INC2} ptr_op_t;

	typedef enum logic [2:0] {
		FILL_HOLD, FILL_SLIDE_BASE, FILL_SLIDE_SET, FILL_SLIDE_STEP,
		FILL_SUPER_INIT, FILL_SUPER_STEP
	} fill_op_t;

	typedef enum logic [3:0] {
		EM_DONE, EM_RD16, EM_RD32, EM_WR8, EM_WR16, EM_OR, EM_AND,
		EM_ADD16, EM_ADD32, EM_SLIDE, EM_SUPER
	} emit_t;

	typedef struct packed {
		logic     ld_in;
		logic     mem_wr;
		logic     mem_rd;
		logic     rd_next;
		ptr_op_t  ptr_op;
		logic     pad_ld;
		fill_op_t fill_op;
		logic     emit;
		emit_t    emit_sel;
	} cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic [3:0] op;
		logic       addr_odd;
		logic       skip;
		logic       pad_cond;
		logic       ptr_lt_len;
		logic       ptr1_lt_len;
		logic       idx_ok;
		logic       rem_zero;
		logic       off_zero;
		logic       enable;
		logic       out_free;
	} status_t;

endpackage

### rtl/core/cce_datapath.sv
// ----------------------------------------------------------------------------
// cce_datapath
// code store, code pointer, fill registers, compare logic and result register
// ----------------------------------------------------------------------------
module cce_datapath #(
	parameter int MAX_CODES = cce_pkg::MAX_CODES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [cce_pkg::CFG_DATA_W-1:0] cfg_data,
	input  cce_pkg::in_item_t              in_data,
	input  cce_pkg::cmd_t                  cmd,
	output cce_pkg::status_t               sts,
	output logic                           out_valid,
	input  logic                           out_ready,
	output cce_pkg::out_item_t             out_data
);
	import cce_pkg::*;

	localparam int AW = (MAX_CODES > 1) ? $clog2(MAX_CODES) : 1;
	localparam int PW = $clog2(MAX_CODES + 2);
	localparam int CW = (PW > 7) ? PW : 7;
	localparam int IW = ((AW > 6) ? AW : 6) + 1;

	// config registers
	logic             enable_q;
	logic [6:0]       count_q;

	// item and engine registers
	in_item_t         in_q;
	logic [PW-1:0]    ptr_q;
	logic [9:0]       pad_q;
	logic [16:0]      rem_q;
	logic [31:0]      faddr_q;
	logic [15:0]      fval_q;
	logic [31:0]      fsteps_q;
	logic [2:0]       off_q;
	logic [47:0]      mem [MAX_CODES];
	logic [47:0]      ent_q;
	logic             out_valid_q;
	out_item_t        out_q;

	logic [CW-1:0]    len;
	logic [CW-1:0]    ptr_w;
	logic [IW-1:0]    idx_w;
	logic [PW-1:0]    rd_ptr;
	logic [31:0]      cw;
	logic [15:0]      cv;
	logic [31:0]      caddr;
	logic [15:0]      d16;
	logic [3:0]       sel;
	logic [15:0]      pad16;
	logic [7:0]       sbyte;
	out_item_t        res;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			count_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CHEAT_ENABLE: enable_q <= cfg_data[0];
				REG_CODE_COUNT:   count_q  <= cfg_data;
				default:          ;
			endcase
		end
	end

	// latched input word
	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			in_q <= in_data;
		end
	end

	// code store, one write and one registered read
	assign idx_w  = IW'(in_q.entry_index);
	assign rd_ptr = cmd.rd_next ? ptr_q + PW'(1) : ptr_q;
	always_ff @(posedge clk) begin
		if (cmd.mem_wr) begin
			mem[idx_w[AW-1:0]] <= {in_q.code_word, in_q.code_value};
		end
		if (cmd.mem_rd) begin
			ent_q <= mem[rd_ptr[AW-1:0]];
		end
	end

	// code pointer and pass pad
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			pad_q <= '0;
		end else begin
			case (cmd.ptr_op)
				PTR_CLR:  ptr_q <= '0;
				PTR_INC1: ptr_q <= ptr_q + PW'(1);
				PTR_INC2: ptr_q <= ptr_q + PW'(2);
				default:  ;
			endcase
			if (cmd.pad_ld) begin
				pad_q <= in_q.pad;
			end
		end
	end

	// slide and super copy registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q    <= '0;
			faddr_q  <= '0;
			fval_q   <= '0;
			fsteps_q <= '0;
			off_q    <= '0;
		end else begin
			case (cmd.fill_op)
				FILL_SLIDE_BASE: begin
					faddr_q <= caddr;
					fval_q  <= cv;
				end
				FILL_SLIDE_SET: begin
					rem_q    <= {1'b0, cw[15:0]};
					fsteps_q <= {cw[31:16], cv};
				end
				FILL_SLIDE_STEP: begin
					rem_q   <= rem_q - 17'd1;
					faddr_q <= faddr_q + {16'd0, fsteps_q[15:0]};
					fval_q  <= fval_q + fsteps_q[31:16];
				end
				FILL_SUPER_INIT: begin
					rem_q   <= {cv, 1'b0};
					faddr_q <= caddr;
					off_q   <= '0;
				end
				FILL_SUPER_STEP: begin
					rem_q   <= rem_q - 17'd1;
					faddr_q <= faddr_q + 32'd1;
					off_q   <= (off_q == SUPER_LAST_OFF) ? 3'd0 : off_q + 3'd1;
				end
				default: ;
			endcase
		end
	end

	// current entry fields and compares
	assign cw    = ent_q[47:16];
	assign cv    = ent_q[15:0];
	assign caddr = {4'd0, cw[27:0]};
	assign d16   = in_q.read_data[15:0];
	assign sel   = cw[7:4];
	assign pad16 = {6'd0, pad_q};
	assign len   = (CW'(count_q) > CW'(MAX_CODES)) ? CW'(MAX_CODES) : CW'(count_q);
	assign ptr_w = CW'(ptr_q);

	always_comb begin
		sts          = '0;
		sts.func     = in_q.func;
		sts.op       = cw[31:28];
		sts.addr_odd = cw[0];
		case (cw[31:28])
			OP_IFEQ: sts.skip = d16 != cv;
			OP_IFNE: sts.skip = d16 == cv;
			OP_IFGT: sts.skip = d16 <= cv;
			OP_IFLT: sts.skip = d16 >= cv;
			default: sts.skip = (d16 & cv) == 16'd0;
		endcase
		case (sel)
			PAD_ONLY: sts.pad_cond = {6'd0, ~pad_q} == cv;
			PAD_ALL:  sts.pad_cond = (pad16 & cv) == cv;
			PAD_NONE: sts.pad_cond = (pad16 & cv) == 16'd0;
			default:  sts.pad_cond = 1'b0;
		endcase
		sts.ptr_lt_len  = ptr_w < len;
		sts.ptr1_lt_len = (ptr_w + CW'(1)) < len;
		sts.idx_ok      = idx_w < IW'(MAX_CODES);
		sts.rem_zero    = rem_q == 17'd0;
		sts.off_zero    = off_q == 3'd0;
		sts.enable      = enable_q;
		sts.out_free    = !out_valid_q || out_ready;
	end

	// super copy byte pick
	always_comb begin
		case (off_q)
			3'd0:    sbyte = cw[31:24];
			3'd1:    sbyte = cw[23:16];
			3'd2:    sbyte = cw[15:8];
			3'd3:    sbyte = cw[7:0];
			3'd4:    sbyte = cv[15:8];
			default: sbyte = cv[7:0];
		endcase
	end

	// result word build
	always_comb begin
		res            = '0;
		res.kind       = KIND_WRITE;
		res.bus_address = caddr;
		res.bus_size   = SIZE_HALF;
		case (cmd.emit_sel)
			EM_DONE: res.kind = KIND_DONE;
			EM_RD16: res.kind = KIND_READ;
			EM_RD32: begin
				res.kind        = KIND_READ;
				res.bus_address = {caddr[31:1], 1'b0};
				res.bus_size    = SIZE_WORD;
			end
			EM_WR8: begin
				res.bus_size   = SIZE_BYTE;
				res.write_data = {24'd0, cv[7:0]};
			end
			EM_WR16:  res.write_data = {16'd0, cv};
			EM_OR:    res.write_data = {16'd0, d16 | cv};
			EM_AND:   res.write_data = {16'd0, d16 & cv};
			EM_ADD16: res.write_data = {16'd0, d16 + cv};
			EM_ADD32: begin
				res.bus_address = {caddr[31:1], 1'b0};
				res.bus_size    = SIZE_WORD;
				res.write_data  = in_q.read_data + {{16{cv[15]}}, cv};
			end
			EM_SLIDE: begin
				res.bus_address = faddr_q;
				res.write_data  = {16'd0, fval_q};
			end
			default: begin
				res.bus_address = faddr_q;
				res.bus_size    = SIZE_BYTE;
				res.write_data  = {24'd0, sbyte};
			end
		endcase
		if (cmd.emit_sel == EM_DONE) begin
			res.bus_address = '0;
			res.bus_size    = SIZE_BYTE;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### rtl/core/cce_ctrl.sv
// ----------------------------------------------------------------------------
// cce_ctrl
// sequencer: takes words, walks the code list and drives the datapath
// ----------------------------------------------------------------------------
module cce_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  cce_pkg::status_t sts,
	output cce_pkg::cmd_t    cmd
);
	import cce_pkg::*;

	state_t state_q, state_d;
	phase_t phase_q, phase_d;

	// state and pass phase registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_WAIT;
			phase_q <= PH_IDLE;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		phase_d  = phase_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_WAIT: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.ld_in = 1'b1;
					state_d   = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (sts.func)
					FUNC_LOAD: begin
						cmd.mem_wr = phase_q == PH_IDLE && sts.idx_ok;
						state_d    = S_WAIT;
					end
					FUNC_START: begin
						if (phase_q != PH_IDLE) begin
							state_d = S_WAIT;
						end else if (sts.enable) begin
							cmd.pad_ld = 1'b1;
							cmd.ptr_op = PTR_CLR;
							state_d    = S_ADV;
						end else if (sts.out_free) begin
							cmd.pad_ld   = 1'b1;
							cmd.ptr_op   = PTR_CLR;
							cmd.emit     = 1'b1;
							cmd.emit_sel = EM_DONE;
							state_d      = S_WAIT;
						end
					end
					FUNC_RDATA: begin
						if (phase_q == PH_RD32) begin
							if (sts.out_free) begin
								cmd.emit     = 1'b1;
								cmd.emit_sel = EM_ADD32;
								phase_d      = PH_WACK;
								state_d      = S_WAIT;
							end
						end else if (phase_q != PH_RD16) begin
							state_d = S_WAIT;
						end else if (sts.op == OP_OR16 || sts.op == OP_AND16 ||
							sts.op == OP_ADD) begin
							if (sts.out_free) begin
								cmd.emit     = 1'b1;
								cmd.emit_sel = (sts.op == OP_OR16) ? EM_OR :
									(sts.op == OP_AND16) ? EM_AND : EM_ADD16;
								phase_d      = PH_WACK;
								state_d      = S_WAIT;
							end
						end else begin
							cmd.ptr_op = sts.skip ? PTR_INC2 : PTR_INC1;
							state_d    = S_ADV;
						end
					end
					default: begin
						if (phase_q == PH_WACK) begin
							cmd.ptr_op = PTR_INC1;
							state_d    = S_ADV;
						end else if (phase_q == PH_SLIDE) begin
							cmd.fill_op = FILL_SLIDE_STEP;
							state_d     = S_SLIDE_CHK;
						end else if (phase_q == PH_SUPER) begin
							cmd.fill_op = FILL_SUPER_STEP;
							state_d     = S_SUPER_NEXT;
						end else begin
							state_d = S_WAIT;
						end
					end
				endcase
			end
			S_ADV: begin
				if (sts.ptr_lt_len) begin
					cmd.mem_rd = 1'b1;
					state_d    = S_DECODE;
				end else if (sts.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = EM_DONE;
					phase_d      = PH_IDLE;
					state_d      = S_WAIT;
				end
			end
			S_DECODE: begin
				case (sts.op)
					OP_OR16, OP_AND16, OP_IFEQ, OP_IFNE, OP_IFGT, OP_IFLT, OP_IFAND,
					OP_ADD, OP_WR8, OP_WR16: begin
						if (sts.out_free) begin
							cmd.emit = 1'b1;
							state_d  = S_WAIT;
							if (sts.op == OP_WR8) begin
								cmd.emit_sel = EM_WR8;
								phase_d      = PH_WACK;
							end else if (sts.op == OP_WR16) begin
								cmd.emit_sel = EM_WR16;
								phase_d      = PH_WACK;
							end else if (sts.op == OP_ADD && sts.addr_odd) begin
								cmd.emit_sel = EM_RD32;
								phase_d      = PH_RD32;
							end else begin
								cmd.emit_sel = EM_RD16;
								phase_d      = PH_RD16;
							end
						end
					end
					OP_SLIDE: begin
						cmd.ptr_op = PTR_INC1;
						if (sts.ptr1_lt_len) begin
							cmd.fill_op = FILL_SLIDE_BASE;
							cmd.mem_rd  = 1'b1;
							cmd.rd_next = 1'b1;
							state_d     = S_SLIDE_SET;
						end else begin
							state_d = S_ADV;
						end
					end
					OP_SUPER: begin
						cmd.fill_op = FILL_SUPER_INIT;
						state_d     = S_SUPER_NEXT;
					end
					OP_PAD: begin
						cmd.ptr_op = sts.pad_cond ? PTR_INC2 : PTR_INC1;
						state_d    = S_ADV;
					end
					default: begin
						cmd.ptr_op = PTR_INC1;
						state_d    = S_ADV;
					end
				endcase
			end
			S_SLIDE_SET: begin
				cmd.fill_op = FILL_SLIDE_SET;
				state_d     = S_SLIDE_CHK;
			end
			S_SLIDE_CHK: begin
				if (sts.rem_zero) begin
					cmd.ptr_op = PTR_INC1;
					state_d    = S_ADV;
				end else if (sts.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = EM_SLIDE;
					phase_d      = PH_SLIDE;
					state_d      = S_WAIT;
				end
			end
			S_SUPER_NEXT: begin
				if (sts.rem_zero || (sts.off_zero && !sts.ptr1_lt_len)) begin
					cmd.ptr_op = PTR_INC1;
					state_d    = S_ADV;
				end else if (sts.off_zero) begin
					cmd.ptr_op  = PTR_INC1;
					cmd.mem_rd  = 1'b1;
					cmd.rd_next = 1'b1;
					state_d     = S_SUPER_EMIT;
				end else begin
					state_d = S_SUPER_EMIT;
				end
			end
			S_SUPER_EMIT: begin
				if (sts.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = EM_SUPER;
					phase_d      = PH_SUPER;
					state_d      = S_WAIT;
				end
			end
			default: state_d = S_WAIT;
		endcase
	end

endmodule

### rtl/core/cheat_code_engine.sv
// path: a taken word is latched, then dispatched; a start walks the code list, and
// each code is read from the store and then decoded, with a slide or a super copy
// set up in S_SLIDE_SET or S_SUPER_NEXT; one word is handled at a time, and in_ready
// returns once a word with no result is dispatched or once a result word is issued
// reset: arst_n clears config, state, pointer, fill and phase registers and the result valid flag;
// the code store has no reset and holds garbage until loaded
// ----------------------------------------------------------------------------
// cheat_code_engine
// code breaker cheat list runner acting as a bus master on an emulated bus
// ----------------------------------------------------------------------------
`include "cheat_code_engine_macros.svh"

module cheat_code_engine #(
	parameter int MAX_CODES = cce_pkg::MAX_CODES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [cce_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  cce_pkg::in_item_t              in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output cce_pkg::out_item_t             out_data
);
	import cce_pkg::*;

	cmd_t    cmd;
	status_t sts;

	// sequencer
	cce_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// storage and arithmetic
	cce_datapath #(
		.MAX_CODES (MAX_CODES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// checks
	`CCE_ASSERT_IMP(a_emit_free, cmd.emit, sts.out_free, "result word overwritten")
	`CCE_ASSERT_NXT(a_busy_after_take, in_valid && in_ready, !in_ready, "word taken while busy")
	`CCE_ASSERT_IMP(a_done_clean, out_valid && out_data.kind == KIND_DONE, out_data.bus_address == 32'd0 && out_data.write_data == 32'd0, "done word not clean")

endmodule
